[rtl/core/est_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_pkg: shared types, constants and sine table for the tone generator
// Sizing constants, register indexes, the job word passed from front to back,
// and the quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package est_pkg;

	// tone shaping
	localparam int FADE_SAMPLES    = 160;
	localparam int SAMPLES_PER_MS  = 16;
	localparam int SINE_TABLE_BITS = 10;

	// register file
	localparam int REG_COUNT  = 3;
	localparam int CFG_IDX_W  = $clog2(REG_COUNT);
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DURATION_MS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = CFG_IDX_W'(2);

	localparam int PHASE_W = 32;
	localparam int DUR_W   = 12;
	localparam int AMP_W   = 15;
	localparam int SINE_W  = 15;
	localparam int SAMPLE_W = 16;

	// sample counter covers the longest tone
	localparam int IDX_W  = $clog2(SAMPLES_PER_MS * 4095 + 1);
	localparam int ENV_W  = $clog2(FADE_SAMPLES + 1);
	localparam int QSIZE  = 1 << SINE_TABLE_BITS;
	localparam int ROM_AW = SINE_TABLE_BITS + 1;

	// scaling: divide by 2^15 (shift) then by FADE_SAMPLES (reciprocal)
	localparam int PROD_W = AMP_W + SINE_W;
	localparam int MAG_W  = PROD_W + ENV_W;
	localparam int MSH_W  = AMP_W + ENV_W;
	localparam int REC_W  = MSH_W + 1;
	localparam longint REC_VAL = (longint'(1) <<< MSH_W) / FADE_SAMPLES;
	localparam logic [REC_W-1:0] REC_C = REC_W'(REC_VAL);
	localparam int QUO_W = 16;

	// queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic              active;
		logic              last;
		logic              neg;
		logic [ROM_AW-1:0] addr;
		logic [ENV_W-1:0]  env;
	} est_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} est_qstat_t;

	// sine table, Q0.15, round(32767 * sin(pi/2 * k / QSIZE))
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = longint'(1) <<< 30;

	typedef logic [0:QSIZE][SINE_W-1:0] sine_rom_t;

	// Q2.30 product
	function automatic longint mul_q30(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint x;
		longint term;
		longint sum;
		for (int k = 0; k <= QSIZE; k++) begin
			x = (HALF_PI_Q30 * longint'(k)) >>> SINE_TABLE_BITS;
			term = x;
			sum = x;
			// Taylor terms x^3/3! .. x^17/17!, each from the one before
			term = mul_q30(mul_q30(term, x), x) / 64'sd6;
			sum = sum - term;
			term = mul_q30(mul_q30(term, x), x) / 64'sd20;
			sum = sum + term;
			term = mul_q30(mul_q30(term, x), x) / 64'sd42;
			sum = sum - term;
			term = mul_q30(mul_q30(term, x), x) / 64'sd72;
			sum = sum + term;
			term = mul_q30(mul_q30(term, x), x) / 64'sd110;
			sum = sum - term;
			term = mul_q30(mul_q30(term, x), x) / 64'sd156;
			sum = sum + term;
			term = mul_q30(mul_q30(term, x), x) / 64'sd210;
			sum = sum - term;
			term = mul_q30(mul_q30(term, x), x) / 64'sd272;
			sum = sum + term;
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > ONE_Q30) begin
				sum = ONE_Q30;
			end
			rom[k] = SINE_W'((sum * 32767 + (ONE_Q30 >>> 1)) >>> 30);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[rtl/core/enveloped_sine_tone_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enveloped_sine_tone_generator_core: enveloped DDS sine tone source
// One tick word in, one PCM sample word out. A 32-bit phase accumulator
// addresses a quarter-wave sine table; the sample is amplitude x envelope x
// sine, truncated toward zero, with linear fade-in and fade-out.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------
//  in      | in  | in_valid/in_stall  | restart
//  out     | out | out_valid/out_stall| sample, active, last
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; the sequencer
// settles a tick in the cycle it is accepted, so it sets the rate. A job goes
// from the queue through the table read, two multiplies, the reciprocal
// multiply and the correction/output register.
// The 4-deep job queue lets the sequencer keep taking ticks while the output
// is stalled; in_stall rises only when the queue is full.
// Async reset clears the sequencer (idle, index and phase zero), registers,
// queue and pipeline valid bits. The table is constant logic, no fill pass.
//
module enveloped_sine_tone_generator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// tick channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   restart,
	// sample channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [est_pkg::SAMPLE_W-1:0]    sample,
	output logic                                   active,
	output logic                                   last,
	// register writes
	input  logic                                   cfg_we,
	input  logic [est_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [est_pkg::CFG_DATA_W-1:0]         cfg_data
);

	logic [est_pkg::PHASE_W-1:0] phase_step_q;
	logic [est_pkg::DUR_W-1:0]   duration_ms_q;
	logic [est_pkg::AMP_W-1:0]   amplitude_q;

	est_pkg::est_job_t   job_in;
	est_pkg::est_job_t   job_out;
	est_pkg::est_qstat_t qstat;
	logic                push;
	logic                pop;

	// register file, read live by both halves; to be written only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= '0;
			duration_ms_q <= '0;
			amplitude_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				est_pkg::REG_PHASE_STEP:  phase_step_q  <= cfg_data[est_pkg::PHASE_W-1:0];
				est_pkg::REG_DURATION_MS: duration_ms_q <= cfg_data[est_pkg::DUR_W-1:0];
				est_pkg::REG_AMPLITUDE:   amplitude_q   <= cfg_data[est_pkg::AMP_W-1:0];
				default: ;  // unmapped index, ignored
			endcase
		end
	end

	// front: index/phase/envelope sequencer
	est_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.restart     (restart),
		.phase_step  (phase_step_q),
		.duration_ms (duration_ms_q),
		.q_full      (qstat.full),
		.push        (push),
		.job         (job_in)
	);

	est_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.qstat  (qstat)
	);

	// back: table lookup and scaling, ends in the output register
	est_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.amplitude (amplitude_q),
		.q_empty   (qstat.empty),
		.job       (job_out),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample),
		.active    (active),
		.last      (last)
	);

endmodule

[rtl/core/est_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_front: tick sequencer
// Accepts ticks, tracks sample index, phase and run state, and emits one job
// word per tick with envelope weight, table address and flags.
// ----------------------------------------------------------------------------
module est_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        restart,
	input  logic [est_pkg::PHASE_W-1:0] phase_step,
	input  logic [est_pkg::DUR_W-1:0]   duration_ms,
	input  logic                        q_full,
	output logic                        push,
	output est_pkg::est_job_t           job
);

	logic [est_pkg::IDX_W-1:0]   idx_q;
	logic [est_pkg::PHASE_W-1:0] phase_q;
	logic                        running_q;

	logic [est_pkg::IDX_W-1:0]   n_len;
	logic [est_pkg::IDX_W-1:0]   idx;
	logic [est_pkg::IDX_W:0]     idx_fade;
	logic [est_pkg::PHASE_W-1:0] ph;
	logic                        run;
	logic                        live;
	logic                        last;
	logic [est_pkg::ENV_W-1:0]   env;
	logic [1:0]                  quad;
	logic [est_pkg::SINE_TABLE_BITS-1:0] k;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		n_len    = est_pkg::IDX_W'(duration_ms * est_pkg::SAMPLES_PER_MS);
		idx      = restart ? '0 : idx_q;
		ph       = restart ? '0 : phase_q;
		run      = restart ? (n_len != '0) : running_q;
		live     = run && (idx < n_len);
		last     = live && (idx + est_pkg::IDX_W'(1) == n_len);
		idx_fade = {1'b0, idx} + (est_pkg::IDX_W + 1)'(est_pkg::FADE_SAMPLES);
		// ramp-up wins over ramp-down on short tones
		if (idx < est_pkg::IDX_W'(est_pkg::FADE_SAMPLES)) begin
			env = est_pkg::ENV_W'(idx);
		end else if (idx_fade > {1'b0, n_len}) begin
			env = est_pkg::ENV_W'(n_len - idx);
		end else begin
			env = est_pkg::ENV_W'(est_pkg::FADE_SAMPLES);
		end
		quad = ph[est_pkg::PHASE_W-1 -: 2];
		k    = ph[est_pkg::PHASE_W-3 -: est_pkg::SINE_TABLE_BITS];

		job.active = live;
		job.last   = last;
		job.neg    = live && quad[1];
		job.addr   = quad[0] ? est_pkg::ROM_AW'(est_pkg::QSIZE) - {1'b0, k} : {1'b0, k};
		job.env    = live ? env : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			phase_q   <= '0;
			running_q <= 1'b0;
		end else if (push) begin
			if (live) begin
				idx_q     <= idx + est_pkg::IDX_W'(1);
				phase_q   <= ph + phase_step;
				running_q <= !last;
			end else begin
				// restart with zero length still rewinds index and phase
				if (restart) begin
					idx_q   <= '0;
					phase_q <= '0;
				end
				running_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/est_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_queue: job queue
// Small flop FIFO between the sequencer and the scaling pipeline.
// ----------------------------------------------------------------------------
module est_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  est_pkg::est_job_t   wdata,
	input  logic                pop,
	output est_pkg::est_job_t   rdata,
	output est_pkg::est_qstat_t qstat
);

	est_pkg::est_job_t               mem_q [0:est_pkg::FIFO_DEPTH-1];
	logic [est_pkg::FIFO_PW-1:0]     wptr_q;
	logic [est_pkg::FIFO_PW-1:0]     rptr_q;
	logic [est_pkg::FIFO_PW:0]       count_q;

	assign qstat.full  = (count_q == (est_pkg::FIFO_PW + 1)'(est_pkg::FIFO_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rdata       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == est_pkg::FIFO_PW'(est_pkg::FIFO_DEPTH - 1)) ?
					'0 : wptr_q + est_pkg::FIFO_PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == est_pkg::FIFO_PW'(est_pkg::FIFO_DEPTH - 1)) ?
					'0 : rptr_q + est_pkg::FIFO_PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (est_pkg::FIFO_PW + 1)'(1);
				2'b01:   count_q <= count_q - (est_pkg::FIFO_PW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/est_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_back: sample scaling pipeline
// Table read, amplitude and envelope multiplies, divide by 2^15*FADE with a
// reciprocal and one correction step, sign restore. Last stage is the output.
// ----------------------------------------------------------------------------
module est_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [est_pkg::AMP_W-1:0]    amplitude,
	input  logic                         q_empty,
	input  est_pkg::est_job_t            job,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [est_pkg::SAMPLE_W-1:0] sample,
	output logic                         active,
	output logic                         last
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [est_pkg::SINE_W-1:0] sine_s1;
	logic [est_pkg::ENV_W-1:0]  env_s1, env_s2;
	logic [2:0]                 flg_s1, flg_s2, flg_s3, flg_s4;  // active, last, neg
	logic [est_pkg::PROD_W-1:0] prod_s2;
	logic [est_pkg::MAG_W-1:0]  mag_s3;
	logic [est_pkg::MSH_W-1:0]  msh_s4;
	logic [est_pkg::QUO_W-1:0]  qe_s4;

	logic signed [est_pkg::SAMPLE_W-1:0] sample_s5;
	logic active_s5, last_s5;

	logic [est_pkg::MSH_W+est_pkg::REC_W-1:0] recip_prod;
	logic [est_pkg::MSH_W-1:0] rem;
	logic [est_pkg::QUO_W-1:0] quo;

	assign adv       = !v_s5 || !out_stall;
	assign pop       = adv && !q_empty;
	assign out_valid = v_s5;
	assign sample    = sample_s5;
	assign active    = active_s5;
	assign last      = last_s5;

	always_comb begin
		recip_prod = est_pkg::MSH_W'(mag_s3 >> est_pkg::AMP_W) * est_pkg::REC_C;
		rem = msh_s4 - est_pkg::MSH_W'(qe_s4 * est_pkg::FADE_SAMPLES);
		quo = (rem >= est_pkg::MSH_W'(est_pkg::FADE_SAMPLES)) ?
			qe_s4 + est_pkg::QUO_W'(1) : qe_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sine_s1 <= est_pkg::SINE_ROM[job.addr];
			env_s1  <= job.env;
			flg_s1  <= {job.active, job.last, job.neg};

			prod_s2 <= est_pkg::PROD_W'(amplitude) * est_pkg::PROD_W'(sine_s1);
			env_s2  <= env_s1;
			flg_s2  <= flg_s1;

			mag_s3  <= est_pkg::MAG_W'(prod_s2) * est_pkg::MAG_W'(env_s2);
			flg_s3  <= flg_s2;

			msh_s4  <= est_pkg::MSH_W'(mag_s3 >> est_pkg::AMP_W);
			qe_s4   <= est_pkg::QUO_W'(recip_prod >> est_pkg::MSH_W);
			flg_s4  <= flg_s3;

			sample_s5 <= flg_s4[0] ? -$signed(quo) : $signed(quo);
			active_s5 <= flg_s4[2];
			last_s5   <= flg_s4[1];
		end
	end

endmodule
